// ===== rtl/phta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package phta_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [32:0] PAGE_ROUND = 33'd4095;
    localparam logic [32:0] PAGE_MASK = {1'b1, 32'hFFFFF000};
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_END = CFG_IDX_W'(1);

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] size;
        logic [7:0]  code;
    } entry_t;

    function automatic logic is_free(entry_t e);
        return e.valid && (e.size != 32'd0) && (e.code == 8'd0);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/page_heap_table_allocator.sv =====
// An allocate is one table scan, with a read state and a check state per entry;
// the longest part of a free is the coalescing pass that
// searches the whole table for a neighbour of every free entry through the one table read port.
// Throughput is one item at a time; the next item is taken once the current one has finished.
// Reset (synchronous, active low) and every write to the heap base or heap end register start a
// clearing pass over the table memory, during which no item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module page_heap_table_allocator
    import phta_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_operation,
    input  wire logic [31:0]          s_request_bytes,
    input  wire logic [7:0]           s_owner_tag,
    input  wire logic [31:0]          s_block_address,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [31:0]               m_granted_address,
    output logic [2:0]                m_status,
    output logic [31:0]               m_free_bytes
);
    // One-hot sequencer. Every table read is a read state followed by a check state,
    // because the table memory has a registered read.
    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_A_RD  = 14'b00000000000100,
        S_A_CHK = 14'b00000000001000,
        S_F_RD  = 14'b00000000010000,
        S_F_CHK = 14'b00000000100000,
        S_C_RD  = 14'b00000001000000,
        S_C_CHK = 14'b00000010000000,
        S_J_RD  = 14'b00000100000000,
        S_J_CHK = 14'b00001000000000,
        S_C_DRP = 14'b00010000000000,
        S_K_RD  = 14'b00100000000000,
        S_K_CHK = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Entry 0 lives in registers; slots 1 and up live in the memory.
    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;

    logic [31:0] base_reg, base_next;
    logic [31:0] end_reg, end_next;
    logic [31:0] e0_addr_reg, e0_addr_next;
    logic [31:0] e0_size_reg, e0_size_next;
    logic [31:0] in_use_reg, in_use_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] jdx_reg, jdx_next;
    logic [IDX_W-1:0] empty_reg, empty_next;
    logic             empty_found_reg, empty_found_next;
    entry_t cur_reg, cur_next;
    logic [IDX_W-1:0] nbr_reg, nbr_next;
    logic [32:0] aligned_reg, aligned_next;
    logic [7:0]  code_reg, code_next;
    logic [31:0] blk_reg, blk_next;
    logic [31:0] res_addr_reg, res_addr_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_addr_reg, m_addr_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [31:0] m_free_reg, m_free_next;

    logic [31:0] region_len;
    logic [31:0] free_now;
    logic        cfg_hit;
    logic        cfg_write;
    logic        rd_adjacent;
    logic        e0_adjacent;
    logic [IDX_W-1:0] slot;
    logic        slot_ok;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit = cfg_write && (cfg_index == REG_HEAP_BASE || cfg_index == REG_HEAP_END);
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_granted_address = m_addr_reg;
    assign m_status = m_status_reg;
    assign m_free_bytes = m_free_reg;

    assign region_len = (end_reg > base_reg) ? (end_reg - base_reg) : 32'd0;
    assign free_now = region_len - in_use_reg;

    // Neighbour tests for the entry held in cur_reg, against the table entry just read
    // and against entry 0.
    assign rd_adjacent = (rdata_reg.addr + rdata_reg.size == cur_reg.addr)
                      || (cur_reg.addr + cur_reg.size == rdata_reg.addr);
    assign e0_adjacent = (e0_size_reg != 32'd0)
                      && ((e0_addr_reg + e0_size_reg == cur_reg.addr)
                       || (cur_reg.addr + cur_reg.size == e0_addr_reg));

    // Lowest empty slot seen so far, including the entry being checked now.
    assign slot_ok = empty_found_reg || !rdata_reg.valid;
    assign slot = empty_found_reg ? empty_reg : idx_reg;

    always_comb begin
        raddr = (state_reg == S_J_RD) ? jdx_reg : idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        state_next = state_reg;
        base_next = base_reg;
        end_next = end_reg;
        e0_addr_next = e0_addr_reg;
        e0_size_next = e0_size_reg;
        in_use_next = in_use_reg;
        idx_next = idx_reg;
        jdx_next = jdx_reg;
        empty_next = empty_reg;
        empty_found_next = empty_found_reg;
        cur_next = cur_reg;
        nbr_next = nbr_reg;
        aligned_next = aligned_reg;
        code_next = code_reg;
        blk_next = blk_reg;
        res_addr_next = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next = m_valid_reg;
        m_addr_next = m_addr_reg;
        m_status_next = m_status_reg;
        m_free_next = m_free_reg;
        we = 1'b0;
        waddr = idx_reg;
        wdata = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR: begin
                // Sweep every slot to empty; entry 0 follows the current region.
                we = 1'b1;
                waddr = idx_reg;
                wdata = '0;
                e0_addr_next = base_reg;
                e0_size_next = region_len;
                in_use_next = 32'd0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    aligned_next = ({1'b0, s_request_bytes} + PAGE_ROUND) & PAGE_MASK;
                    code_next = (s_owner_tag != 8'd0) ? s_owner_tag : 8'd1;
                    blk_next = s_block_address;
                    res_addr_next = 32'd0;
                    idx_next = IDX_W'(1);
                    empty_found_next = 1'b0;
                    if (s_operation) begin
                        state_next = S_F_RD;
                    end else if (s_request_bytes == 32'd0) begin
                        res_status_next = ST_ZERO;
                        state_next = S_DONE;
                    end else if (s_request_bytes >= free_now) begin
                        res_status_next = ST_NO_SPACE;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_A_RD;
                    end
                end
            end
            S_A_RD: begin
                state_next = S_A_CHK;
            end
            S_A_CHK: begin
                // Exact-fit search; the lowest empty slot is noted on the way.
                if (is_free(rdata_reg) && ({1'b0, rdata_reg.size} == aligned_reg)) begin
                    we = 1'b1;
                    waddr = idx_reg;
                    wdata = rdata_reg;
                    wdata.code = code_reg;
                    in_use_next = in_use_reg + rdata_reg.size;
                    res_addr_next = rdata_reg.addr;
                    res_status_next = ST_OK;
                    state_next = S_DONE;
                end else begin
                    if (!empty_found_reg && !rdata_reg.valid) begin
                        empty_found_next = 1'b1;
                        empty_next = idx_reg;
                    end
                    if (idx_reg != LAST_IDX) begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_A_RD;
                    end else if (aligned_reg > {1'b0, e0_size_reg}) begin
                        res_status_next = ST_NO_SPACE;
                        state_next = S_DONE;
                    end else if (!slot_ok) begin
                        res_status_next = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        // Carve the block from the front of entry 0.
                        we = 1'b1;
                        waddr = slot;
                        wdata.valid = 1'b1;
                        wdata.addr = e0_addr_reg;
                        wdata.size = aligned_reg[31:0];
                        wdata.code = code_reg;
                        e0_addr_next = e0_addr_reg + aligned_reg[31:0];
                        e0_size_next = e0_size_reg - aligned_reg[31:0];
                        in_use_next = in_use_reg + aligned_reg[31:0];
                        res_addr_next = e0_addr_reg;
                        res_status_next = ST_OK;
                        state_next = S_DONE;
                    end
                end
            end
            S_F_RD: begin
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                if (rdata_reg.valid && rdata_reg.size != 32'd0 && rdata_reg.code != 8'd0
                        && rdata_reg.addr == blk_reg) begin
                    we = 1'b1;
                    waddr = idx_reg;
                    wdata = rdata_reg;
                    wdata.code = 8'd0;
                    in_use_next = in_use_reg - rdata_reg.size;
                    res_status_next = ST_OK;
                    idx_next = IDX_W'(1);
                    state_next = S_C_RD;
                end else if (idx_reg != LAST_IDX) begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_F_RD;
                end else begin
                    res_status_next = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
            end
            S_C_RD: begin
                state_next = S_C_CHK;
            end
            S_C_CHK: begin
                cur_next = rdata_reg;
                if (is_free(rdata_reg)) begin
                    jdx_next = IDX_W'(1);
                    state_next = S_J_RD;
                end else if (idx_reg != LAST_IDX) begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_C_RD;
                end else begin
                    idx_next = IDX_W'(1);
                    state_next = S_K_RD;
                end
            end
            S_J_RD: begin
                // Entry 0 is the first candidate; when it is the neighbour, nothing merges.
                if (jdx_reg == IDX_W'(1) && e0_adjacent) begin
                    if (idx_reg != LAST_IDX) begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_C_RD;
                    end else begin
                        idx_next = IDX_W'(1);
                        state_next = S_K_RD;
                    end
                end else begin
                    state_next = S_J_CHK;
                end
            end
            S_J_CHK: begin
                if (jdx_reg != idx_reg && is_free(rdata_reg) && rd_adjacent) begin
                    we = 1'b1;
                    waddr = idx_reg;
                    wdata = cur_reg;
                    if (cur_reg.addr > rdata_reg.addr) begin
                        wdata.addr = rdata_reg.addr;
                    end
                    wdata.size = cur_reg.size + rdata_reg.size;
                    nbr_next = jdx_reg;
                    state_next = S_C_DRP;
                end else if (jdx_reg != LAST_IDX) begin
                    jdx_next = jdx_reg + 1'b1;
                    state_next = S_J_RD;
                end else if (idx_reg != LAST_IDX) begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_C_RD;
                end else begin
                    idx_next = IDX_W'(1);
                    state_next = S_K_RD;
                end
            end
            S_C_DRP: begin
                we = 1'b1;
                waddr = nbr_reg;
                wdata = '0;
                if (idx_reg != LAST_IDX) begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_C_RD;
                end else begin
                    idx_next = IDX_W'(1);
                    state_next = S_K_RD;
                end
            end
            S_K_RD: begin
                state_next = S_K_CHK;
            end
            S_K_CHK: begin
                // Fold the first free block that ends at entry 0's start into entry 0.
                if (is_free(rdata_reg) && (rdata_reg.addr + rdata_reg.size == e0_addr_reg)) begin
                    e0_addr_next = rdata_reg.addr;
                    e0_size_next = e0_size_reg + rdata_reg.size;
                    we = 1'b1;
                    waddr = idx_reg;
                    wdata = '0;
                    state_next = S_DONE;
                end else if (idx_reg != LAST_IDX) begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_K_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_addr_next = (res_status_reg == ST_OK) ? res_addr_reg : 32'd0;
                    m_status_next = res_status_reg;
                    m_free_next = free_now;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase

        if (cfg_hit) begin
            if (cfg_index == REG_HEAP_BASE) begin
                base_next = cfg_data;
            end else begin
                end_next = cfg_data;
            end
            idx_next = '0;
            state_next = S_CLR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            base_reg <= 32'd1048576;
            end_reg <= 32'd17825792;
            idx_reg <= '0;
            in_use_reg <= 32'd0;
            m_valid_reg <= 1'b0;
            empty_found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            base_reg <= base_next;
            end_reg <= end_next;
            idx_reg <= idx_next;
            in_use_reg <= in_use_next;
            m_valid_reg <= m_valid_next;
            empty_found_reg <= empty_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_addr_reg <= e0_addr_next;
        e0_size_reg <= e0_size_next;
        jdx_reg <= jdx_next;
        empty_reg <= empty_next;
        cur_reg <= cur_next;
        nbr_reg <= nbr_next;
        aligned_reg <= aligned_next;
        code_reg <= code_next;
        blk_reg <= blk_next;
        res_addr_reg <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg <= m_addr_next;
        m_status_reg <= m_status_next;
        m_free_reg <= m_free_next;
    end
endmodule
`default_nettype wire
